>>> src/itp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_pkg
// Types, character codes and the digit decoder shared by the integer text
// parser and its step logic.
// ----------------------------------------------------------------------------
package itp_pkg;

  typedef enum logic [2:0] {
    PH_DONE   = 3'd0,
    PH_SPACE  = 3'd1,
    PH_PREFIX = 3'd2,
    PH_ZERO   = 3'd3,
    PH_DIGITS = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] acc;
    logic        neg;
    logic [5:0]  base;
  } parse_state_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_X   = 8'h78;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  localparam logic [5:0] BASE_AUTO = 6'd0;
  localparam logic [5:0] BASE_OCT  = 6'd8;
  localparam logic [5:0] BASE_DEC  = 6'd10;
  localparam logic [5:0] BASE_HEX  = 6'd16;

  // Byte address of the radix register on the configuration port.
  localparam logic [2:0] REG_NUMBER_BASE = 3'd0;

  localparam logic [7:0] NOT_DIGIT = 8'd255;

  // Value of an alphanumeric character, or NOT_DIGIT for anything else.
  function automatic logic [7:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = NOT_DIGIT;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      d = c - CH_ZERO;
    end else if (c inside {[CH_LO_A:CH_LO_Z]}) begin
      d = c - CH_LO_A + 8'd10;
    end else if (c inside {[CH_UP_A:CH_UP_Z]}) begin
      d = c - CH_UP_A + 8'd10;
    end
    return d;
  endfunction

  function automatic logic is_white(input logic [7:0] c);
    return (c inside {[CH_TAB:CH_CR], CH_SPACE});
  endfunction

endpackage

>>> src/integer_text_parser_with_base.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_text_parser_with_base
// Streaming strtol-style parser: one character per request, one signed
// 32-bit result per number.
// ----------------------------------------------------------------------------
// Usage:
//   Characters arrive on the in_valid/in_ready channel, one per request, with
//   first set on the first character of each string. Leading white space and
//   one sign are skipped, the radix prefix is handled, and digits are
//   accumulated modulo 2^32. The first character that is not a digit of the
//   radix (NUL included) produces one request on the out_valid/out_ready
//   channel carrying value and end_offset; later characters are dropped
//   until the next first flag.
//   Each character is applied in the cycle it is accepted; a result appears in
//   the cycle after its terminating character. One character per cycle is
//   sustained while the result side does not stall. The output register holds
//   a result while out_ready is low; in_ready then stays high only as long as
//   the register is free or being emptied. number_base is to be written over
//   the APB port (address 0) only while idle, which the block does not
//   enforce; it is sampled at each first flag. Reset sets the radix to 10 and
//   leaves the parser waiting for a first flag with no result pending.
// ----------------------------------------------------------------------------
module integer_text_parser_with_base #(
  parameter int MAX_CHARS = 4096
) (
  input  logic               clk,
  input  logic               rst,
  // Character channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         char_code,
  input  logic               first,
  // Result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value,
  output logic [12:0]        end_offset,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import itp_pkg::*;

  localparam int POS_W = $clog2(MAX_CHARS + 1);
  localparam int OFF_W = 13;

  logic [5:0]       number_base;
  parse_state_t     state;
  parse_state_t     state_next;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic             emit;
  logic [31:0]      result;
  logic [POS_W-1:0] result_pos;
  logic             accept;
  logic             cfg_write;
  logic [POS_W+OFF_W-1:0] pos_ext;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_DEC;
    end else if (cfg_write && paddr == REG_NUMBER_BASE) begin
      number_base <= pwdata[5:0];
    end
  end

  assign prdata = (paddr == REG_NUMBER_BASE) ? {26'd0, number_base} : 32'd0;

  itp_step #(
    .POS_W(POS_W)
  ) u_step (
    .char_code   (char_code),
    .first       (first),
    .number_base (number_base),
    .max_pos     (POS_W'(MAX_CHARS)),
    .state       (state),
    .pos         (pos),
    .state_next  (state_next),
    .pos_next    (pos_next),
    .emit        (emit),
    .result      (result),
    .result_pos  (result_pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase <= PH_DONE;
      state.acc   <= '0;
      state.neg   <= 1'b0;
      state.base  <= BASE_DEC;
      pos         <= '0;
    end else if (accept) begin
      state <= state_next;
      pos   <= pos_next;
    end
  end

  assign pos_ext = {{OFF_W{1'b0}}, result_pos};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      value      <= result;
      end_offset <= pos_ext[OFF_W-1:0];
    end
  end

  // A character arriving while no parse is open never makes a result.
  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    accept && !first && state.phase == PH_DONE |=> !out_valid)
    else $error("result produced with no parse open");

  // A result closes the parse.
  a_emit_closes: assert property (@(posedge clk) disable iff (rst)
    accept && emit |=> out_valid && state.phase == PH_DONE)
    else $error("parse still open after its result");

  // The character position saturates.
  a_pos_sat: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(MAX_CHARS))
    else $error("character position beyond limit");

  // Digit accumulation never runs with the auto-detect radix.
  a_base_resolved: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_DIGITS |-> state.base != BASE_AUTO)
    else $error("digit phase with unresolved radix");

endmodule

>>> src/itp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_step
// Combinational parse step: applies one character to the parse state and
// tells whether the character ends the number.
// ----------------------------------------------------------------------------
module itp_step #(
  parameter int POS_W = 13
) (
  input  logic [7:0]          char_code,
  input  logic                first,
  input  logic [5:0]          number_base,
  input  logic [POS_W-1:0]    max_pos,
  input  itp_pkg::parse_state_t state,
  input  logic [POS_W-1:0]    pos,
  output itp_pkg::parse_state_t state_next,
  output logic [POS_W-1:0]    pos_next,
  output logic                emit,
  output logic [31:0]         result,
  output logic [POS_W-1:0]    result_pos
);
  import itp_pkg::*;

  parse_state_t     cur;
  logic [POS_W-1:0] cur_pos;
  logic             stop;
  logic             adv;
  logic [7:0]       d;

  always_comb begin
    if (first) begin
      cur.phase = PH_SPACE;
      cur.acc   = '0;
      cur.neg   = 1'b0;
      cur.base  = number_base;
      cur_pos   = '0;
    end else begin
      cur     = state;
      cur_pos = pos;
    end
  end

  always_comb begin
    state_next = cur;
    stop       = 1'b0;
    adv        = 1'b0;
    emit       = 1'b0;
    d          = digit_of(char_code);

    if (cur.phase == PH_DONE) begin
      stop = 1'b1;
    end

    if (!stop && state_next.phase == PH_SPACE) begin
      if (is_white(char_code)) begin
        adv  = 1'b1;
        stop = 1'b1;
      end else begin
        state_next.phase = PH_PREFIX;
        if (char_code == CH_MINUS) begin
          state_next.neg = 1'b1;
          adv  = 1'b1;
          stop = 1'b1;
        end else if (char_code == CH_PLUS) begin
          adv  = 1'b1;
          stop = 1'b1;
        end
      end
    end

    if (!stop && state_next.phase == PH_PREFIX) begin
      if (cur.base == BASE_AUTO) begin
        if (char_code == CH_ZERO) begin
          state_next.base  = BASE_OCT;
          state_next.phase = PH_ZERO;
          adv  = 1'b1;
          stop = 1'b1;
        end else begin
          state_next.base = BASE_DEC;
        end
      end else if (cur.base == BASE_HEX && char_code == CH_ZERO) begin
        state_next.phase = PH_ZERO;
        adv  = 1'b1;
        stop = 1'b1;
      end
      if (!stop) begin
        state_next.phase = PH_DIGITS;
      end
    end

    if (!stop && state_next.phase == PH_ZERO) begin
      state_next.phase = PH_DIGITS;
      if (char_code == CH_LO_X || char_code == CH_UP_X) begin
        state_next.base = BASE_HEX;
        adv  = 1'b1;
        stop = 1'b1;
      end
    end

    // Digit phase, with the radix as resolved by the prefix logic above.
    if (!stop) begin
      if (d < {2'b00, state_next.base}) begin
        state_next.acc = 32'(cur.acc * 32'(state_next.base)) + 32'(d);
        adv = 1'b1;
      end else begin
        state_next.phase = PH_DONE;
        emit = 1'b1;
      end
    end
  end

  assign pos_next   = (adv && cur_pos < max_pos) ? cur_pos + POS_W'(1) : cur_pos;
  assign result     = cur.neg ? (32'd0 - cur.acc) : cur.acc;
  assign result_pos = cur_pos;

endmodule

>>> tb/tb_integer_text_parser_with_base.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_text_parser_with_base
// Streams character strings into the parser under several radix settings and
// checks every parsed number against a cycle-free model of the parse. Both
// channels stall at random, and the result side is held off once long enough
// to back up the character side.
// ----------------------------------------------------------------------------
module tb_integer_text_parser_with_base;
  import itp_pkg::*;

  localparam int         MAX_CHARS       = 4096;
  localparam int         STUCK_LIMIT     = 2000;
  localparam int         DRAIN_LIMIT     = 1000;
  localparam int         HOLD_CYCLES     = 300;
  localparam int         CHARS_PER_RADIX = 170;
  localparam int         NO_TERM         = -1;

  typedef struct {
    logic signed [31:0] val;
    logic [12:0]        off;
  } parsed_number_t;

  // Tracks the parse of the character stream and holds the numbers it yields.
  class number_scoreboard;
    logic [5:0]     radix_reg;
    phase_t         phase;
    logic [31:0]    acc;
    logic           neg;
    logic [5:0]     radix;
    int             pos;
    parsed_number_t pending_numbers[$];
    int             errors;
    int             numbers_checked;

    function new();
      radix_reg       = BASE_DEC;
      phase           = PH_DONE;
      acc             = '0;
      neg             = 1'b0;
      radix           = BASE_DEC;
      pos             = 0;
      errors          = 0;
      numbers_checked = 0;
    endfunction

    function logic [7:0] char_value(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
      if (c >= CH_LO_A && c <= CH_LO_Z) return c - CH_LO_A + 8'd10;
      if (c >= CH_UP_A && c <= CH_UP_Z) return c - CH_UP_A + 8'd10;
      return 8'hFF;
    endfunction

    function void step_pos();
      if (pos < MAX_CHARS) pos++;
    endfunction

    function void note_request(logic [7:0] c, logic f);
      logic [7:0]     d;
      parsed_number_t num;
      if (f) begin
        phase = PH_SPACE;
        acc   = '0;
        neg   = 1'b0;
        radix = radix_reg;
        pos   = 0;
      end
      if (phase == PH_DONE) return;
      if (phase == PH_SPACE) begin
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          step_pos();
          return;
        end
        phase = PH_PREFIX;
        if (c == CH_MINUS) begin
          neg = 1'b1;
          step_pos();
          return;
        end
        if (c == CH_PLUS) begin
          step_pos();
          return;
        end
      end
      if (phase == PH_PREFIX) begin
        if (radix == BASE_AUTO) begin
          if (c == CH_ZERO) begin
            radix = BASE_OCT;
            phase = PH_ZERO;
            step_pos();
            return;
          end
          radix = BASE_DEC;
        end else if (radix == BASE_HEX && c == CH_ZERO) begin
          phase = PH_ZERO;
          step_pos();
          return;
        end
        phase = PH_DIGITS;
      end
      // A leading zero may still turn out to open a hex prefix.
      if (phase == PH_ZERO) begin
        phase = PH_DIGITS;
        if (c == CH_LO_X || c == CH_UP_X) begin
          radix = BASE_HEX;
          step_pos();
          return;
        end
      end
      d = char_value(c);
      if (d < {2'b00, radix}) begin
        acc = acc * radix + d;
        step_pos();
        return;
      end
      phase   = PH_DONE;
      num.val = neg ? (32'd0 - acc) : acc;
      num.off = 13'(pos);
      pending_numbers.push_back(num);
    endfunction

    function void check_result(logic signed [31:0] v, logic [12:0] off);
      parsed_number_t num;
      if (pending_numbers.size() == 0) begin
        $error("result value=%0d end_offset=%0d arrived with none expected", v, off);
        errors++;
        return;
      end
      num = pending_numbers.pop_front();
      numbers_checked++;
      if (v !== num.val) begin
        $error("value: expected %0d, got %0d", num.val, v);
        errors++;
      end
      if (off !== num.off) begin
        $error("end_offset: expected %0d, got %0d", num.off, off);
        errors++;
      end
    endfunction
  endclass

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic [7:0]         char_code  = '0;
  logic               first      = 1'b0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic signed [31:0] value;
  logic [12:0]        end_offset;
  logic               psel       = 1'b0;
  logic               penable    = 1'b0;
  logic               pwrite     = 1'b0;
  logic [2:0]         paddr      = '0;
  logic [31:0]        pwdata     = '0;
  logic [31:0]        prdata;
  logic               pready;

  number_scoreboard scb = new();

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit fresh_string;
  int hold_reqs = 0;
  int chars_sent = 0;
  int chars_counted = 0;
  int strings_sent = 0;
  int stuck_cycles = 0;

  integer_text_parser_with_base #(
    .MAX_CHARS(MAX_CHARS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .first     (first),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .end_offset(end_offset),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      scb.check_result(value, end_offset);
    end
  end

  // Result side: random stalls, plus a long hold whenever one is requested.
  initial begin
    int holds_done;
    int hold_left;
    holds_done = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_done != hold_reqs) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (rx_idle_en && $urandom_range(99) < 15) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", STUCK_LIMIT);
      $display("tb_integer_text_parser_with_base NOT OK");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic f);
    in_valid  <= 1'b1;
    char_code <= c;
    first     <= f;
    do @(posedge clk); while (!in_ready);
    scb.note_request(c, f);
    chars_sent++;
    if (tx_idle_en && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic emit(input logic [7:0] c);
    send_char(c, fresh_string);
    if (fresh_string) strings_sent++;
    fresh_string = 1'b0;
    chars_counted++;
  endtask

  task automatic send_text(input string s, input int term);
    fresh_string = 1'b1;
    for (int i = 0; i < s.len(); i++) begin
      emit(s[i]);
    end
    if (term != NO_TERM) emit(term[7:0]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (scb.pending_numbers.size() != 0) @(posedge clk);
    // A string cut short yields no number, so give the last character time.
    repeat (4) @(posedge clk);
  endtask

  task automatic set_radix(input logic [5:0] b);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_NUMBER_BASE;
    pwdata  <= {26'd0, b};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    scb.radix_reg = b;
  endtask

  function automatic logic [7:0] digit_char(input int v);
    if (v < 10) return CH_ZERO + 8'(v);
    return ($urandom_range(1) ? CH_LO_A : CH_UP_A) + 8'(v - 10);
  endfunction

  function automatic logic [7:0] white_char();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
  endfunction

  // Mostly well-formed numbers with random content; the rest is noise.
  task automatic random_string();
    int n;
    int r;
    int top;
    logic [5:0] b;
    b = scb.radix_reg;
    fresh_string = 1'b1;
    if ($urandom_range(99) < 12) begin
      n = $urandom_range(1, 8);
      repeat (n) emit(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(0, 2)) emit(white_char());
      r = $urandom_range(99);
      if (r < 30) emit(CH_MINUS);
      else if (r < 45) emit(CH_PLUS);
      r = $urandom_range(99);
      if ((b == BASE_AUTO || b == BASE_HEX) && r < 40) begin
        emit(CH_ZERO);
        emit($urandom_range(1) ? CH_LO_X : CH_UP_X);
      end else if (b == BASE_AUTO && r < 60) begin
        emit(CH_ZERO);
      end
      top = (b == BASE_AUTO) ? 16 : ((b > 36) ? 36 : int'(b));
      n = $urandom_range(0, 12);
      repeat (n) emit(digit_char($urandom_range(top - 1)));
      r = $urandom_range(99);
      if (r < 45) emit(CH_NUL);
      else if (r < 90) emit(8'($urandom_range(255)));
    end
    // Characters after the end of a number are dropped by the parser.
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(255)), 1'b0);
    end
  endtask

  task automatic random_run();
    int start;
    start = chars_counted;
    while (chars_counted - start < CHARS_PER_RADIX) random_string();
  endtask

  initial begin
    int waited;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Radix 10 from reset.
    send_char(8'hFF, 1'b0);
    send_char(CH_NUL, 1'b0);
    send_text(" \t-2147483648", CH_NUL);
    send_text("4294967297", CH_SPACE);
    send_text("+", 8'hFF);
    send_text("-", CH_SPACE);
    send_text("45", NO_TERM);
    send_text("7", CH_NUL);
    send_char(CH_UP_Z, 1'b0);
    send_text("", CH_NUL);

    set_radix(BASE_AUTO);
    send_text("0x1F", CH_NUL);
    send_text("017", CH_NUL);
    send_text("0Xg", NO_TERM);
    send_text("08", NO_TERM);
    send_text("-99", CH_NUL);
    random_run();

    set_radix(BASE_HEX);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_text("0xfF", CH_NUL);
    send_text("-0XAbC", CH_NUL);
    send_text("0,", NO_TERM);
    send_text("0xz", NO_TERM);
    send_text("ffffffff", CH_NUL);
    random_run();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    set_radix(BASE_OCT);
    send_text("7778", NO_TERM);
    random_run();
    set_radix(6'd2);
    send_text("10112", NO_TERM);
    random_run();
    set_radix(6'd1);
    send_text("0001", NO_TERM);
    random_run();
    set_radix(6'd36);
    send_text("zZ", CH_NUL);
    random_run();
    set_radix(6'd37);
    send_text("zZ9!", NO_TERM);
    random_run();
    set_radix(6'd63);
    send_text("Az.", NO_TERM);
    random_run();

    set_radix(BASE_DEC);
    hold_reqs++;
    random_run();

    in_valid <= 1'b0;
    waited = 0;
    while (scb.pending_numbers.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (scb.pending_numbers.size() != 0) begin
      $error("%0d numbers never arrived", scb.pending_numbers.size());
      scb.errors++;
    end
    $display("Sent %0d characters in %0d strings and checked %0d numbers,",
             chars_sent, strings_sent, scb.numbers_checked);
    $display("over radix 10, 0, 16, 8, 2, 1, 36, 37 and 63 with stalls on both sides.");
    if (scb.errors == 0) begin
      $display("tb_integer_text_parser_with_base OK");
    end else begin
      $display("tb_integer_text_parser_with_base NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
src/itp_pkg.sv
src/itp_step.sv
src/integer_text_parser_with_base.sv
tb/tb_integer_text_parser_with_base.sv
